@@ sv/fwtm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, register indexes and helpers for the fuzzy word/term matcher.
// Used by the cell, the cell row and the top level; depends on nothing.
package fwtm_pkg;

  localparam int ROW_W = 5;
  localparam int TERM_REG_CHARS = 16;
  localparam logic [ROW_W-1:0] ROW_MAX = 5'd31;
  localparam logic [7:0] LEN_MAX = 8'd255;

  localparam logic [1:0] REG_TERM_LENGTH = 2'd0;
  localparam logic [1:0] REG_TERM_CHARS_LOW = 2'd1;
  localparam logic [1:0] REG_TERM_CHARS_HIGH = 2'd2;

  localparam logic [1:0] TOL_NONE = 2'd0;
  localparam logic [1:0] TOL_ONE = 2'd1;
  localparam logic [1:0] TOL_TWO = 2'd2;

  // Wavefront beat handed from one cell to the next.
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] old_row;
    logic [ROW_W-1:0] new_row;
    logic             old_pbit;
  } link_t;

  function automatic logic [7:0] mask_fold(input logic [7:0] c, input logic [7:0] mask);
    logic [7:0] m;
    m = c & mask;
    if (m >= 8'd65 && m <= 8'd90) begin
      m = m + 8'd32;
    end
    return m;
  endfunction

  function automatic logic [ROW_W-1:0] sat_inc(input logic [ROW_W-1:0] v);
    return (v == ROW_MAX) ? ROW_MAX : v + 5'd1;
  endfunction

  function automatic logic [1:0] tolerance(input logic [4:0] l);
    logic [1:0] t;
    if (l < 5'd3) begin
      t = TOL_NONE;
    end else if (l <= 5'd5) begin
      t = TOL_ONE;
    end else begin
      t = TOL_TWO;
    end
    return t;
  endfunction

endpackage

@@ sv/fwtm_cell.sv @@
`timescale 1ns / 1ps
// One column of the Levenshtein row with its substring prefix bit.
// Depends on fwtm_pkg for the link type and helpers.
module fwtm_cell #(
  parameter logic [4:0] INIT = 5'd0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  logic            active,
  input  logic [7:0]      term_ch,
  input  logic [7:0]      word_ch,
  input  fwtm_pkg::link_t link_in,
  output fwtm_pkg::link_t link_out,
  output logic [4:0]      row,
  output logic            pbit
);
  import fwtm_pkg::*;

  logic             eq;
  logic [ROW_W-1:0] m1;
  logic [ROW_W-1:0] m2;
  logic [ROW_W-1:0] row_next;

  assign eq = (term_ch == word_ch);

  always_comb begin
    m1 = (link_in.new_row < row) ? link_in.new_row : row;
    m2 = (link_in.old_row < m1) ? link_in.old_row : m1;
    row_next = eq ? link_in.old_row : sat_inc(m2);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row <= INIT;
      pbit <= 1'b0;
      link_out.valid <= 1'b0;
    end else begin
      link_out.valid <= link_in.valid;
      if (link_in.valid) begin
        link_out.old_row <= row;
        link_out.old_pbit <= pbit;
        if (active) begin
          row <= row_next;
          pbit <= link_in.old_pbit & eq;
          link_out.new_row <= row_next;
        end else begin
          // Columns beyond the term keep their value and hold no prefix.
          pbit <= 1'b0;
          link_out.new_row <= row;
        end
      end
    end
  end

endmodule

@@ sv/fwtm_chain.sv @@
`timescale 1ns / 1ps
// Row of matcher cells, columns 1 to MAX_TERM_CHARS, linked left to right.
// Depends on fwtm_pkg and fwtm_cell.
module fwtm_chain #(
  parameter int MAX_TERM_CHARS = 16,
  parameter int CHAR_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              clear,
  input  logic [4:0]                        eff_len,
  input  logic [fwtm_pkg::TERM_REG_CHARS-1:0][7:0] term_chars,
  input  logic [7:0]                        word_ch,
  input  fwtm_pkg::link_t                   link_in,
  output logic                              done,
  output logic [MAX_TERM_CHARS-1:0][4:0]    rows,
  output logic [MAX_TERM_CHARS-1:0]         pbits
);
  import fwtm_pkg::*;

  localparam logic [7:0] CHAR_MASK = (CHAR_BITS >= 8) ? 8'hFF : 8'((1 << CHAR_BITS) - 1);

  link_t links [MAX_TERM_CHARS+1];

  assign links[0] = link_in;
  assign done = links[MAX_TERM_CHARS].valid;

  for (genvar j = 1; j <= MAX_TERM_CHARS; j++) begin : g_cell
    localparam logic [4:0] INIT = (j > 31) ? 5'd31 : 5'(j);
    logic [7:0] tch;
    logic       act;

    if (j <= TERM_REG_CHARS) begin : g_char
      assign tch = mask_fold(term_chars[j-1], CHAR_MASK);
    end else begin : g_zero
      assign tch = mask_fold(8'd0, CHAR_MASK);
    end

    assign act = (j <= int'(eff_len));

    fwtm_cell #(.INIT(INIT)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .clear    (clear),
      .active   (act),
      .term_ch  (tch),
      .word_ch  (word_ch),
      .link_in  (links[j-1]),
      .link_out (links[j]),
      .row      (rows[j-1]),
      .pbit     (pbits[j-1])
    );
  end

endmodule

@@ sv/fuzzy_word_term_matcher.sv @@
`timescale 1ns / 1ps
// Fuzzy word/term matcher: bounded Levenshtein distance plus substring search.
// Each character is taken only once the update wavefront of the previous one has crossed the
// cell row, one cell a cycle; in_stall stays high until then, so characters do not overlap.
// A result is stored once the wavefront of the last character leaves the row, later
// while an earlier result is still stalled, and the input stalls until it can be stored.
// Synchronous reset clears the row to its initial distances and sets term_length to 1.
module fuzzy_word_term_matcher #(
  parameter int MAX_TERM_CHARS = 16,
  parameter int CHAR_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        matched,
  output logic        substring_hit,
  output logic        length_within,
  output logic [4:0]  edit_distance,
  output logic [7:0]  word_length
);
  import fwtm_pkg::*;

  localparam logic [7:0] CHAR_MASK = (CHAR_BITS >= 8) ? 8'hFF : 8'((1 << CHAR_BITS) - 1);
  localparam int LEN_CAP = (MAX_TERM_CHARS < TERM_REG_CHARS) ? MAX_TERM_CHARS : TERM_REG_CHARS;
  localparam int IDX_W = (MAX_TERM_CHARS < 2) ? 1 : $clog2(MAX_TERM_CHARS + 1);

  logic [4:0]  term_length;
  logic [63:0] term_chars_low;
  logic [63:0] term_chars_high;

  logic [ROW_W-1:0] row0;
  link_t            link0;
  logic             found;
  logic [7:0]       length_count;
  logic [7:0]       word_ch;
  logic             last_r;
  logic             busy;
  logic             fin_pend;

  logic [4:0]       eff_len;
  logic             accept;
  logic             done;
  logic             fire;
  logic             clear;
  logic [MAX_TERM_CHARS-1:0][4:0] rows;
  logic [MAX_TERM_CHARS-1:0]      pbits;
  logic [MAX_TERM_CHARS:0][4:0]   row_all;
  logic [MAX_TERM_CHARS:0]        pbit_all;
  logic [TERM_REG_CHARS-1:0][7:0] term_chars;
  logic [IDX_W-1:0] sel;
  logic             hit;
  logic [1:0]       thr;
  logic [7:0]       gap;
  logic             lw;
  logic [4:0]       distance;

  assign eff_len = (term_length > 5'(LEN_CAP)) ? 5'(LEN_CAP) : term_length;
  assign term_chars = {term_chars_high, term_chars_low};

  assign in_stall = busy;
  assign accept = in_valid && !busy;
  assign fire = (done || fin_pend) && (!last_r || !out_valid || !out_stall);
  assign clear = fire && last_r;

  assign row_all = {rows, row0};
  assign pbit_all = {pbits, 1'b0};
  assign sel = IDX_W'(eff_len);

  always_comb begin
    hit = (eff_len == 5'd0) || found || pbit_all[sel];
    thr = tolerance(eff_len);
    gap = (length_count > {3'd0, eff_len}) ? length_count - {3'd0, eff_len}
                                            : {3'd0, eff_len} - length_count;
    lw = (gap <= {6'd0, thr});
    distance = row_all[sel];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_length <= 5'd1;
      term_chars_low <= 64'd0;
      term_chars_high <= 64'd0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_TERM_LENGTH:     term_length <= cfg_data[4:0];
        REG_TERM_CHARS_LOW:  term_chars_low <= cfg_data;
        REG_TERM_CHARS_HIGH: term_chars_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Column zero of the row and the per-word counters live here.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row0 <= 5'd0;
      link0.valid <= 1'b0;
      found <= 1'b0;
      length_count <= 8'd0;
    end else begin
      link0.valid <= accept;
      if (accept) begin
        row0 <= sat_inc(row0);
        link0.old_row <= row0;
        link0.new_row <= sat_inc(row0);
        link0.old_pbit <= 1'b1;
        if (length_count != LEN_MAX) begin
          length_count <= length_count + 8'd1;
        end
      end
      if (fire) begin
        found <= hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_ch <= mask_fold(char_code, CHAR_MASK);
      last_r <= last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin_pend <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (fire) begin
        busy <= 1'b0;
      end
      fin_pend <= (done || fin_pend) && !fire;
    end
  end

  // The result register frees the row for the next word while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (clear) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      matched <= hit || (lw && (distance <= {3'd0, thr}));
      substring_hit <= hit;
      length_within <= lw;
      edit_distance <= distance;
      word_length <= length_count;
    end
  end

  fwtm_chain #(
    .MAX_TERM_CHARS (MAX_TERM_CHARS),
    .CHAR_BITS      (CHAR_BITS)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .clear      (clear),
    .eff_len    (eff_len),
    .term_chars (term_chars),
    .word_ch    (word_ch),
    .link_in    (link0),
    .done       (done),
    .rows       (rows),
    .pbits      (pbits)
  );

endmodule

@@ tb/sv/tb_fuzzy_word_term_matcher.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the fuzzy word/term matcher: streams words against a range of
// search terms and checks every verdict against a behavioural model of the row update.
// Depends on fwtm_pkg and the fuzzy_word_term_matcher RTL.
module tb_fuzzy_word_term_matcher;
  import fwtm_pkg::*;

  localparam int TERM_CHARS = 16;
  localparam int ROW_LATENCY = TERM_CHARS + 2;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [7:0] CHAR_MASK = 8'hFF;
  localparam int TIMEOUT_NS = 4_000_000;

  typedef struct packed {
    logic       matched;
    logic       substring_hit;
    logic       length_within;
    logic [4:0] edit_distance;
    logic [7:0] word_length;
  } verdict_t;

  logic        clk;
  logic        rst;
  logic        cfg_write_enable;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  char_code;
  logic        last_char;
  logic        out_valid;
  logic        out_stall;
  logic        matched;
  logic        substring_hit;
  logic        length_within;
  logic [4:0]  edit_distance;
  logic [7:0]  word_length;

  // Shadow of the block: term registers and per-word state.
  logic [4:0]  len_reg;
  logic [63:0] chars_lo;
  logic [63:0] chars_hi;
  logic [4:0]  dist_row [0:TERM_CHARS];
  logic [15:0] prefix_bits;
  logic        found;
  logic [7:0]  char_count;

  verdict_t    pending_verdicts[$];
  logic [7:0]  word_q[$];

  int tx_idle_max = 0;
  int rx_idle_max = 0;
  int hold_left = 0;
  int mismatches = 0;
  int chars_sent = 0;

  fuzzy_word_term_matcher uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .char_code        (char_code),
    .last_char        (last_char),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .matched          (matched),
    .substring_hit    (substring_hit),
    .length_within    (length_within),
    .edit_distance    (edit_distance),
    .word_length      (word_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    logic [7:0] m;
    m = c & CHAR_MASK;
    if (m >= "A" && m <= "Z") begin
      m = m + 8'd32;
    end
    return m;
  endfunction

  function automatic logic [7:0] term_byte(input int i);
    if (i < 8) begin
      return chars_lo[8*i +: 8];
    end else if (i < TERM_CHARS) begin
      return chars_hi[8*(i-8) +: 8];
    end
    return 8'd0;
  endfunction

  function automatic int active_len();
    int l;
    l = len_reg;
    if (l > TERM_CHARS) begin
      l = TERM_CHARS;
    end
    return l;
  endfunction

  function automatic logic [4:0] sat_step(input logic [4:0] v);
    return (v == ROW_MAX) ? ROW_MAX : v + 5'd1;
  endfunction

  function automatic void restart_word();
    for (int j = 0; j <= TERM_CHARS; j++) begin
      dist_row[j] = 5'(j);
    end
    prefix_bits = '0;
    found = 1'b0;
    char_count = '0;
  endfunction

  // Advances the shadow row by one character and, on the last one, queues the verdict.
  task automatic fold_in_char(input logic [7:0] c, input logic last);
    logic [4:0]  nxt [0:TERM_CHARS];
    logic [4:0]  m;
    logic [15:0] eq_bits;
    logic [7:0]  cf;
    verdict_t    v;
    int l, tol, gap, wl;
    l = active_len();
    cf = fold_byte(c);
    eq_bits = '0;
    nxt[0] = sat_step(dist_row[0]);
    for (int j = 1; j <= l; j++) begin
      if (fold_byte(term_byte(j - 1)) == cf) begin
        nxt[j] = dist_row[j - 1];
        eq_bits[j - 1] = 1'b1;
      end else begin
        m = dist_row[j];
        if (nxt[j - 1] < m) begin
          m = nxt[j - 1];
        end
        if (dist_row[j - 1] < m) begin
          m = dist_row[j - 1];
        end
        nxt[j] = sat_step(m);
      end
    end
    // Entries past the active length keep whatever they last held.
    for (int j = 0; j <= l; j++) begin
      dist_row[j] = nxt[j];
    end
    prefix_bits = ((prefix_bits << 1) | 16'd1) & eq_bits;
    if (l == 0) begin
      found = 1'b1;
    end else if (prefix_bits[l - 1]) begin
      found = 1'b1;
    end
    if (char_count != LEN_MAX) begin
      char_count = char_count + 8'd1;
    end
    if (last) begin
      tol = (l < 3) ? 0 : ((l <= 5) ? 1 : 2);
      wl = char_count;
      gap = (wl > l) ? wl - l : l - wl;
      v.substring_hit = found;
      v.length_within = (gap <= tol);
      v.edit_distance = dist_row[l];
      v.word_length = char_count;
      v.matched = v.substring_hit | (v.length_within & (int'(dist_row[l]) <= tol));
      pending_verdicts.push_back(v);
      restart_word();
    end
  endtask

  // Result side: compare each accepted beat with the oldest expected verdict.
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {matched, substring_hit, length_within, edit_distance, word_length};
      if (pending_verdicts.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected verdict at %0t: m=%0b s=%0b l=%0b d=%0d n=%0d", $time,
                   got.matched, got.substring_hit, got.length_within, got.edit_distance,
                   got.word_length);
        end
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.matched !== want.matched || got.substring_hit !== want.substring_hit ||
            got.length_within !== want.length_within ||
            got.edit_distance !== want.edit_distance ||
            got.word_length !== want.word_length) begin
          if (mismatches < 10) begin
            $display("verdict mismatch at %0t: expected m=%0b s=%0b l=%0b d=%0d n=%0d",
                     $time, want.matched, want.substring_hit, want.length_within,
                     want.edit_distance, want.word_length);
            $display("                          actual m=%0b s=%0b l=%0b d=%0d n=%0d",
                     got.matched, got.substring_hit, got.length_within, got.edit_distance,
                     got.word_length);
          end
          mismatches++;
        end
      end
      hold_left = $urandom_range(0, rx_idle_max);
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // All driving tasks are entered and left just after a falling edge.
  // Valid is low on entry and is dropped again once the beat has been taken.
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    repeat (gap) @(negedge clk);
    in_valid <= 1'b1;
    char_code <= c;
    last_char <= last;
    do begin
      @(posedge clk);
    end while (in_stall);
    fold_in_char(c, last);
    chars_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_word();
    for (int i = 0; i < word_q.size(); i++) begin
      send_char(word_q[i], i == word_q.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    word_q.delete();
    for (int i = 0; i < s.len(); i++) begin
      word_q.push_back(s[i]);
    end
    send_word();
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_TERM_LENGTH: len_reg = data[4:0];
      REG_TERM_CHARS_LOW: chars_lo = data;
      REG_TERM_CHARS_HIGH: chars_hi = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    @(negedge clk);
  endtask

  // Holds the sender off until every verdict is in and the row has drained.
  task automatic settle();
    while (pending_verdicts.size() != 0) begin
      @(negedge clk);
    end
    repeat (ROW_LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [7:0] flip_case(input logic [7:0] b);
    if (((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) && $urandom_range(0, 1) == 1) begin
      return b ^ 8'h20;
    end
    return b;
  endfunction

  function automatic logic [7:0] letter();
    int r;
    logic [7:0] b;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      b = "a" + 8'($urandom_range(0, 5));
    end else if (r < 9) begin
      b = "a" + 8'($urandom_range(0, 25));
    end else begin
      // Codes just outside the folded range.
      case ($urandom_range(0, 3))
        0: b = 8'h40;
        1: b = 8'h5B;
        2: b = 8'h60;
        default: b = 8'h7B;
      endcase
    end
    return flip_case(b);
  endfunction

  // Half are near misses of the term or words that contain it; the rest use its letters or are noise.
  task automatic build_word();
    int mode, l, n, k, pos;
    word_q.delete();
    l = active_len();
    mode = $urandom_range(0, 9);
    if (mode <= 2) begin
      for (int i = 0; i < l; i++) begin
        word_q.push_back(flip_case(term_byte(i)));
      end
      n = $urandom_range(0, 3);
      repeat (n) begin
        k = $urandom_range(0, 2);
        pos = (word_q.size() == 0) ? 0 : $urandom_range(0, word_q.size() - 1);
        if (k == 0 && word_q.size() > 0) begin
          word_q[pos] = letter();
        end else if (k == 1) begin
          word_q.insert(pos, letter());
        end else if (word_q.size() > 1) begin
          word_q.delete(pos);
        end
      end
    end else if (mode <= 4) begin
      n = $urandom_range(0, 4);
      repeat (n) word_q.push_back(letter());
      for (int i = 0; i < l; i++) begin
        word_q.push_back(flip_case(term_byte(i)));
      end
      n = $urandom_range(0, 4);
      repeat (n) word_q.push_back(letter());
    end else if (mode <= 6) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        if (l > 0 && $urandom_range(0, 2) != 0) begin
          word_q.push_back(flip_case(term_byte($urandom_range(0, l - 1))));
        end else begin
          word_q.push_back(letter());
        end
      end
    end else if (mode == 7) begin
      n = $urandom_range(1, 20);
      repeat (n) word_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 16);
      repeat (n) word_q.push_back(letter());
    end
    if (word_q.size() == 0) begin
      word_q.push_back(letter());
    end
  endtask

  task automatic test_reset_state();
    tx_idle_max = 0;
    rx_idle_max = 0;
    // Reset term is one NUL character.
    send_char(8'h00, 1'b1);
    send_char("a", 1'b1);
  endtask

  task automatic test_case_folding();
    settle();
    write_reg(REG_TERM_LENGTH, 64'd5);
    write_reg(REG_TERM_CHARS_LOW, 64'h0000_006F_6C6C_6548);
    send_text("hELLO");
    send_text("hallo");
    settle();
    write_reg(REG_TERM_LENGTH, 64'd2);
    write_reg(REG_TERM_CHARS_LOW, 64'h5B40);
    send_text("@[");
    send_char(8'h60, 1'b0);
    send_char(8'h7B, 1'b1);
  endtask

  task automatic test_empty_term();
    settle();
    write_reg(REG_TERM_LENGTH, 64'd0);
    send_text("xy");
  endtask

  task automatic test_length_clamp();
    settle();
    write_reg(REG_TERM_LENGTH, '1);
    write_reg(REG_TERM_CHARS_LOW, '1);
    write_reg(REG_TERM_CHARS_HIGH, '1);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_mid_word_update();
    settle();
    write_reg(REG_TERM_LENGTH, 64'd3);
    write_reg(REG_TERM_CHARS_LOW, 64'h636261);
    send_char("a", 1'b0);
    send_char("b", 1'b0);
    settle();
    write_reg(REG_TERM_LENGTH, 64'd2);
    send_char("x", 1'b1);
  endtask

  task automatic test_unused_index();
    settle();
    write_reg(REG_TERM_LENGTH, 64'd1);
    write_reg(REG_TERM_CHARS_LOW, 64'h61);
    write_reg(REG_UNUSED, '1);
    send_char("A", 1'b1);
  endtask

  task automatic test_random_words();
    int plan [14] = '{3, 1, 2, 5, 6, 16, 0, 4, 8, 31, 12, 17, 10, 7};
    logic [63:0] lo, hi, len_word;
    logic [7:0] b;
    int start;
    for (int p = 0; p < 14; p++) begin
      settle();
      lo = '0;
      hi = '0;
      for (int k = 0; k < TERM_CHARS; k++) begin
        b = ($urandom_range(0, 9) < 8) ? letter() : 8'($urandom_range(0, 255));
        if (k < 8) begin
          lo[8*k +: 8] = b;
        end else begin
          hi[8*(k-8) +: 8] = b;
        end
      end
      if (p == 5) begin
        lo = '1;
        hi = '1;
      end
      // Only the low five bits of the length word count.
      len_word = (p % 2 == 1) ? {$urandom, $urandom} : 64'd0;
      len_word[4:0] = 5'(plan[p]);
      write_reg(REG_TERM_LENGTH, len_word);
      write_reg(REG_TERM_CHARS_LOW, lo);
      write_reg(REG_TERM_CHARS_HIGH, hi);
      tx_idle_max = (p % 3 == 2) ? 0 : 11;
      rx_idle_max = (p % 4 == 1) ? 0 : 11;
      start = chars_sent;
      while (chars_sent - start < 57) begin
        build_word();
        send_word();
      end
    end
  endtask

  // Words long enough to saturate the length count and the distance row.
  task automatic test_long_words();
    settle();
    tx_idle_max = 11;
    rx_idle_max = 11;
    write_reg(REG_TERM_LENGTH, 64'd16);
    write_reg(REG_TERM_CHARS_LOW, {$urandom, $urandom});
    write_reg(REG_TERM_CHARS_HIGH, {$urandom, $urandom});
    word_q.delete();
    repeat (280) word_q.push_back(letter());
    send_word();
    settle();
    tx_idle_max = 0;
    write_reg(REG_TERM_LENGTH, 64'd0);
    word_q.delete();
    repeat (270) word_q.push_back(8'($urandom_range(0, 255)));
    send_word();
  endtask

  initial begin
    rst = 1'b1;
    cfg_write_enable = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    char_code = '0;
    last_char = 1'b0;
    len_reg = 5'd1;
    chars_lo = '0;
    chars_hi = '0;
    restart_word();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_state();
    test_case_folding();
    test_empty_term();
    test_length_clamp();
    test_mid_word_update();
    test_unused_index();
    test_random_words();
    test_long_words();

    settle();
    repeat (ROW_LATENCY) @(negedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ fuzzy_word_term_matcher.f @@
sv/fwtm_pkg.sv
sv/fwtm_cell.sv
sv/fwtm_chain.sv
sv/fuzzy_word_term_matcher.sv
tb/sv/tb_fuzzy_word_term_matcher.sv
